[hdl/b254_pkg.sv]
`default_nettype none

package b254_pkg;

   localparam int SEQ_DIGITS_DEF  = 2;
   localparam int TIME_DIGITS_DEF = 4;
   localparam int TTL_DIGITS_DEF  = 2;

   localparam int SEQ_W    = 16;
   localparam int TTL_W    = 16;
   localparam int TS_W     = 48;
   localparam int BYTE_W   = 8;

   localparam int TSV_W    = 30;
   localparam int TSLO_W   = 31;
   localparam int QMOD_W   = 19;
   localparam int QE_W     = 22;
   localparam int REM_W    = 9;

   localparam logic [20:0]       TS_RECIP     = 21'd1125899;
   localparam logic [TSV_W-1:0]  TS_MODULUS   = 30'd1000000000;
   localparam logic [25:0]       DIV127_RECIP = 26'd33818640;
   localparam logic [REM_W-1:0]  RADIX        = 9'd254;
   localparam logic [BYTE_W-1:0] PAD_BYTE     = 8'd255;
   localparam logic [BYTE_W-1:0] ZERO_DIGIT   = 8'd254;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic {
      MODE_HEADER  = 1'b0,
      MODE_PAYLOAD = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type mode;
      logic     plast;
   } item_ctl_type;

   function automatic longint unsigned radix_power(input int count);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < count; i++) begin
         p = p * 254;
      end
      return p;
   endfunction

   // estimate of v / 254, low by at most one
   function automatic logic [QE_W-1:0] quot_est(input logic [TSV_W-1:0] v);
      logic [54:0] prod;
      prod = 55'(v[TSV_W-1:1]) * 55'(DIV127_RECIP);
      return prod[32 +: QE_W];
   endfunction

endpackage

`default_nettype wire

[hdl/b254_req_if.sv]
`default_nettype none

interface b254_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [b254_pkg::SEQ_W-1:0]    seq_number;
   logic [b254_pkg::TTL_W-1:0]    ttl_value;
   logic [b254_pkg::TS_W-1:0]     timestamp_ms;
   logic [b254_pkg::BYTE_W-1:0]   payload_byte;
   logic                          payload_last;

   modport source (
      output valid, mode, seq_number, ttl_value, timestamp_ms, payload_byte, payload_last,
      input  ready
   );

   modport sink (
      input  valid, mode, seq_number, ttl_value, timestamp_ms, payload_byte, payload_last,
      output ready
   );
endinterface

`default_nettype wire

[hdl/b254_rsp_if.sv]
`default_nettype none

interface b254_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [b254_pkg::BYTE_W-1:0]   out_byte;
   logic                          run_last;
   logic                          datagram_end;

   modport source (
      output valid, out_byte, run_last, datagram_end,
      input  ready
   );

   modport sink (
      input  valid, out_byte, run_last, datagram_end,
      output ready
   );
endinterface

`default_nettype wire

[hdl/b254_front.sv]
`default_nettype none

module b254_front #(
   parameter int SEQ_DIGITS  = b254_pkg::SEQ_DIGITS_DEF,
   parameter int TIME_DIGITS = b254_pkg::TIME_DIGITS_DEF,
   parameter int TTL_DIGITS  = b254_pkg::TTL_DIGITS_DEF,
   localparam int HDR_LEN    = SEQ_DIGITS + TIME_DIGITS + TTL_DIGITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   b254_req_if.sink                                    req_bus,
   output logic                                        push_valid,
   input  wire logic                                   push_ready,
   output b254_pkg::item_ctl_type                      push_ctl,
   output logic [HDR_LEN-1:0][b254_pkg::BYTE_W-1:0]    push_bytes
);

   localparam int NUM_LANES = 3;
   localparam int NDIG =
      (TIME_DIGITS >= SEQ_DIGITS && TIME_DIGITS >= TTL_DIGITS) ? TIME_DIGITS :
      ((SEQ_DIGITS >= TTL_DIGITS) ? SEQ_DIGITS : TTL_DIGITS);
   localparam int LANE_DIG [NUM_LANES] = '{SEQ_DIGITS, TIME_DIGITS, TTL_DIGITS};
   localparam int LANE_END [NUM_LANES] =
      '{SEQ_DIGITS - 1, SEQ_DIGITS + TIME_DIGITS - 1, HDR_LEN - 1};
   localparam longint unsigned SEQ_LIM = b254_pkg::radix_power(SEQ_DIGITS) - 1;
   localparam longint unsigned TTL_LIM = b254_pkg::radix_power(TTL_DIGITS) - 1;

   typedef struct packed {
      b254_pkg::item_ctl_type                          ctl;
      logic [b254_pkg::BYTE_W-1:0]                     pbyte;
      logic [NUM_LANES-1:0][b254_pkg::TSV_W-1:0]       val;
      logic [NUM_LANES-1:0][b254_pkg::QE_W-1:0]        qe;
      logic [HDR_LEN-1:0][b254_pkg::BYTE_W-1:0]        hdr;
   } dstage_type;

   logic advance;

   logic                              v1_ff, v2_ff, v3_ff, v4_ff;
   b254_pkg::item_ctl_type            ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl1_in;
   logic [b254_pkg::BYTE_W-1:0]       pb1_ff, pb2_ff, pb3_ff, pb4_ff;
   logic [b254_pkg::SEQ_W-1:0]        seq1_ff, seq2_ff, seq3_ff, seq4_ff, seq1_in;
   logic [b254_pkg::TTL_W-1:0]        ttl1_ff, ttl2_ff, ttl3_ff, ttl4_ff, ttl1_in;
   logic [b254_pkg::TSLO_W-1:0]       tslo1_ff, tslo2_ff;
   logic [b254_pkg::QMOD_W-1:0]       qm1_ff, qm1_in;
   logic [b254_pkg::TSLO_W-1:0]       p2_ff, p2_in;
   logic [b254_pkg::TSLO_W-1:0]       r3_ff, r3_in;
   logic [b254_pkg::TSV_W-1:0]        ts4_ff, ts4_in;
   logic [48:0]                       prod1, prod2;

   dstage_type         chain [2*NDIG+1];
   logic [2*NDIG:0]    chain_v;

   assign advance       = !chain_v[2*NDIG] || push_ready;
   assign req_bus.ready = advance;

   assign ctl1_in = '{mode: b254_pkg::mode_type'(req_bus.mode), plast: req_bus.payload_last};
   assign seq1_in = ({48'd0, req_bus.seq_number} > SEQ_LIM) ? 16'(SEQ_LIM) : req_bus.seq_number;
   assign ttl1_in = ({48'd0, req_bus.ttl_value} > TTL_LIM) ? 16'(TTL_LIM) : req_bus.ttl_value;
   assign prod1   = 49'(req_bus.timestamp_ms[b254_pkg::TS_W-1:20]) * 49'(b254_pkg::TS_RECIP);
   assign qm1_in  = prod1[48:30];
   assign prod2   = 49'(qm1_ff) * 49'(b254_pkg::TS_MODULUS);
   assign p2_in   = prod2[b254_pkg::TSLO_W-1:0];
   assign r3_in   = tslo2_ff - p2_ff;
   assign ts4_in  = (r3_ff >= {1'b0, b254_pkg::TS_MODULUS}) ?
                    b254_pkg::TSV_W'(r3_ff - {1'b0, b254_pkg::TS_MODULUS}) :
                    r3_ff[b254_pkg::TSV_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl1_ff  <= ctl1_in;
         pb1_ff   <= req_bus.payload_byte;
         seq1_ff  <= seq1_in;
         ttl1_ff  <= ttl1_in;
         tslo1_ff <= req_bus.timestamp_ms[b254_pkg::TSLO_W-1:0];
         qm1_ff   <= qm1_in;
         ctl2_ff  <= ctl1_ff;
         pb2_ff   <= pb1_ff;
         seq2_ff  <= seq1_ff;
         ttl2_ff  <= ttl1_ff;
         tslo2_ff <= tslo1_ff;
         p2_ff    <= p2_in;
         ctl3_ff  <= ctl2_ff;
         pb3_ff   <= pb2_ff;
         seq3_ff  <= seq2_ff;
         ttl3_ff  <= ttl2_ff;
         r3_ff    <= r3_in;
         ctl4_ff  <= ctl3_ff;
         pb4_ff   <= pb3_ff;
         seq4_ff  <= seq3_ff;
         ttl4_ff  <= ttl3_ff;
         ts4_ff   <= ts4_in;
      end
   end

   always_comb begin
      chain[0]          = '0;
      chain[0].ctl      = ctl4_ff;
      chain[0].pbyte    = pb4_ff;
      chain[0].val[0]   = b254_pkg::TSV_W'(seq4_ff);
      chain[0].val[1]   = ts4_ff;
      chain[0].val[2]   = b254_pkg::TSV_W'(ttl4_ff);
   end
   assign chain_v[0] = v4_ff;

   for (genvar k = 0; k < NDIG; k++) begin : g_dig
      dstage_type a_ff, a_in, b_ff, b_in;
      logic       av_ff, bv_ff;

      always_comb begin
         a_in = chain[2*k];
         for (int l = 0; l < NUM_LANES; l++) begin
            a_in.qe[l] = b254_pkg::quot_est(chain[2*k].val[l]);
         end
      end

      always_comb begin
         logic [b254_pkg::QE_W-1:0]   q;
         logic [b254_pkg::REM_W-1:0]  rem;
         logic [b254_pkg::BYTE_W-1:0] digit;
         b_in = a_ff;
         for (int l = 0; l < NUM_LANES; l++) begin
            q   = a_ff.qe[l];
            rem = a_ff.val[l][b254_pkg::REM_W-1:0] - {q[0], 8'd0} + {q[7:0], 1'b0};
            if (rem >= b254_pkg::RADIX) begin
               q   = q + 1'b1;
               rem = rem - b254_pkg::RADIX;
            end
            if (a_ff.val[l] == '0) begin
               digit = b254_pkg::PAD_BYTE;
            end else if (rem == '0) begin
               digit = b254_pkg::ZERO_DIGIT;
            end else begin
               digit = rem[b254_pkg::BYTE_W-1:0];
            end
            b_in.val[l] = b254_pkg::TSV_W'(q);
            if (k < LANE_DIG[l]) begin
               b_in.hdr[LANE_END[l] - k] = digit;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            av_ff <= 1'b0;
            bv_ff <= 1'b0;
         end else if (advance) begin
            av_ff <= chain_v[2*k];
            bv_ff <= av_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            a_ff <= a_in;
            b_ff <= b_in;
         end
      end

      assign chain[2*k+1]   = a_ff;
      assign chain[2*k+2]   = b_ff;
      assign chain_v[2*k+1] = av_ff;
      assign chain_v[2*k+2] = bv_ff;
   end

   assign push_valid = chain_v[2*NDIG];
   assign push_ctl   = chain[2*NDIG].ctl;

   always_comb begin
      push_bytes = chain[2*NDIG].hdr;
      if (chain[2*NDIG].ctl.mode == b254_pkg::MODE_PAYLOAD) begin
         push_bytes[0] = chain[2*NDIG].pbyte;
      end
   end

endmodule

`default_nettype wire

[hdl/b254_queue.sv]
`default_nettype none

module b254_queue #(
   parameter int HDR_LEN = b254_pkg::SEQ_DIGITS_DEF + b254_pkg::TIME_DIGITS_DEF +
                           b254_pkg::TTL_DIGITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   push_valid,
   output logic                                        push_ready,
   input  wire b254_pkg::item_ctl_type                 push_ctl,
   input  wire logic [HDR_LEN-1:0][b254_pkg::BYTE_W-1:0] push_bytes,
   output logic                                        head_valid,
   input  wire logic                                   head_pop,
   output b254_pkg::item_ctl_type                      head_ctl,
   output logic [HDR_LEN-1:0][b254_pkg::BYTE_W-1:0]    head_bytes
);

   localparam int DEPTH = b254_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b254_pkg::item_ctl_type                     ctl_ff   [DEPTH];
   logic [HDR_LEN-1:0][b254_pkg::BYTE_W-1:0]   bytes_ff [DEPTH];
   logic [PTR_W-1:0]                           wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                           count_ff, count_in;
   logic                                       do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = head_pop && head_valid;
   assign head_ctl   = ctl_ff[rd_ptr_ff];
   assign head_bytes = bytes_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ctl_ff[wr_ptr_ff]   <= push_ctl;
         bytes_ff[wr_ptr_ff] <= push_bytes;
      end
   end

endmodule

`default_nettype wire

[hdl/b254_back.sv]
`default_nettype none

module b254_back #(
   parameter int HDR_LEN = b254_pkg::SEQ_DIGITS_DEF + b254_pkg::TIME_DIGITS_DEF +
                           b254_pkg::TTL_DIGITS_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     head_valid,
   output logic                                          head_pop,
   input  wire b254_pkg::item_ctl_type                   head_ctl,
   input  wire logic [HDR_LEN-1:0][b254_pkg::BYTE_W-1:0] head_bytes,
   b254_rsp_if.source                                    rsp_bus
);

   localparam int IDX_W = $clog2(HDR_LEN);

   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic                         valid_ff, valid_in;
   logic [b254_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                         last_ff, end_ff;
   logic                         load, take, is_payload, end_of_item;

   assign load        = !valid_ff || rsp_bus.ready;
   assign take        = load && head_valid;
   assign is_payload  = (head_ctl.mode == b254_pkg::MODE_PAYLOAD);
   assign end_of_item = is_payload || (idx_ff == IDX_W'(HDR_LEN - 1));
   assign head_pop    = take && end_of_item;
   assign byte_in     = is_payload ? head_bytes[0] : head_bytes[idx_ff];

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (take) begin
         idx_in   = end_of_item ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= byte_in;
         last_ff <= end_of_item;
         end_ff  <= is_payload && head_ctl.plast;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.out_byte     = byte_ff;
   assign rsp_bus.run_last     = last_ff;
   assign rsp_bus.datagram_end = end_ff;

endmodule

`default_nettype wire

[hdl/base254_header_encoder_unit.sv]
`default_nettype none

// Channel   Bus      Dir  Content
// req       req_bus  in   mode, seq_number, ttl_value, timestamp_ms, payload_byte, payload_last
// rsp       rsp_bus  out  out_byte, run_last, datagram_end
//
// A payload item gives one byte; a header item gives SEQ_DIGITS + TIME_DIGITS + TTL_DIGITS
// bytes, one per cycle while rsp_bus.ready allows, and the output serializer sets that rate.
// The first byte passes the front pipeline's input registers and its estimate and correction
// registers for each digit, then the queue and the output register.
// The front takes one item per cycle until its four-entry queue fills, then stalls.
// Reset is synchronous and clears only the valid flags, pointers, entry count and byte index.

module base254_header_encoder_unit #(
   parameter int SEQ_DIGITS  = b254_pkg::SEQ_DIGITS_DEF,
   parameter int TIME_DIGITS = b254_pkg::TIME_DIGITS_DEF,
   parameter int TTL_DIGITS  = b254_pkg::TTL_DIGITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   b254_req_if.sink   req_bus,
   b254_rsp_if.source rsp_bus
);

   localparam int HDR_LEN = SEQ_DIGITS + TIME_DIGITS + TTL_DIGITS;

   logic                                       push_valid, push_ready;
   b254_pkg::item_ctl_type                     push_ctl, head_ctl;
   logic [HDR_LEN-1:0][b254_pkg::BYTE_W-1:0]   push_bytes, head_bytes;
   logic                                       head_valid, head_pop;

   b254_front #(
      .SEQ_DIGITS  (SEQ_DIGITS),
      .TIME_DIGITS (TIME_DIGITS),
      .TTL_DIGITS  (TTL_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ctl   (push_ctl),
      .push_bytes (push_bytes)
   );

   b254_queue #(
      .HDR_LEN (HDR_LEN)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ctl   (push_ctl),
      .push_bytes (push_bytes),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_ctl   (head_ctl),
      .head_bytes (head_bytes)
   );

   b254_back #(
      .HDR_LEN (HDR_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_ctl   (head_ctl),
      .head_bytes (head_bytes),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

[sim/base254_header_encoder_checker.sv]
`timescale 1ns / 100ps

module base254_header_encoder_checker (
   input  wire logic clock,
   input  wire logic reset,
   b254_req_if       req_mon,
   b254_rsp_if       rsp_mon,
   output int        error_count,
   output int        pending_count
);
   import b254_pkg::*;

   localparam int               DIGIT_BASE   = 254;
   localparam longint unsigned  MS_PER_EPOCH = 64'd1000000000;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              datagram_end;
   } enc_byte_type;

   enc_byte_type encoded_bytes[$];
   enc_byte_type want;

   function automatic void push_digits(input longint unsigned value, input int count,
                                       input bit ends_item);
      longint unsigned   ceiling;
      longint unsigned   rest;
      logic [BYTE_W-1:0] digits [6];
      ceiling = 1;
      for (int i = 0; i < count; i++) begin
         ceiling = ceiling * DIGIT_BASE;
      end
      ceiling = ceiling - 1;
      rest = (value > ceiling) ? ceiling : value;
      for (int i = 0; i < count; i++) begin
         if (rest == 0) begin
            digits[i] = PAD_BYTE;
         end else begin
            digits[i] = (rest % DIGIT_BASE == 0) ? ZERO_DIGIT : BYTE_W'(rest % DIGIT_BASE);
            rest = rest / DIGIT_BASE;
         end
      end
      for (int i = count - 1; i >= 0; i--) begin
         encoded_bytes.push_back('{digits[i], ends_item && (i == 0), 1'b0});
      end
   endfunction

   function automatic void encode_item();
      longint unsigned stamp;
      stamp = longint'(req_mon.timestamp_ms);
      if (req_mon.mode == MODE_PAYLOAD) begin
         encoded_bytes.push_back('{req_mon.payload_byte, 1'b1, req_mon.payload_last});
      end else begin
         push_digits(longint'(req_mon.seq_number), SEQ_DIGITS_DEF, 1'b0);
         push_digits(stamp % MS_PER_EPOCH, TIME_DIGITS_DEF, 1'b0);
         push_digits(longint'(req_mon.ttl_value), TTL_DIGITS_DEF, 1'b1);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         error_count   = 0;
         pending_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (encoded_bytes.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual byte %02h last %b end %b",
                        $time, rsp_mon.out_byte, rsp_mon.run_last, rsp_mon.datagram_end);
               error_count++;
            end else begin
               want = encoded_bytes.pop_front();
               if (rsp_mon.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, want.out_byte, rsp_mon.out_byte);
                  error_count++;
               end
               if (rsp_mon.run_last !== want.run_last) begin
                  $display("%0t: run_last expected %b actual %b",
                           $time, want.run_last, rsp_mon.run_last);
                  error_count++;
               end
               if (rsp_mon.datagram_end !== want.datagram_end) begin
                  $display("%0t: datagram_end expected %b actual %b",
                           $time, want.datagram_end, rsp_mon.datagram_end);
                  error_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            encode_item();
         end
         pending_count = encoded_bytes.size();
      end
   end

endmodule

[sim/base254_header_encoder_unit_tb.sv]
`timescale 1ns / 100ps

module base254_header_encoder_unit_tb;
   import b254_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 420;
   localparam int LONG_HOLD    = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   pending_count;
   int   cycle_count = 0;
   int   items_sent  = 0;
   bit   tight       = 1'b0;
   bit   long_hold_req = 1'b0;
   bit   hold_active   = 1'b0;

   b254_req_if req_bus ();
   b254_rsp_if rsp_bus ();

   base254_header_encoder_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   base254_header_encoder_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tight || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SEQ_W-1:0] pick_count();
      case ($urandom_range(0, 3))
         0: return SEQ_W'($urandom_range(0, 300));
         1: return SEQ_W'($urandom_range(64400, 65535));
         2: return SEQ_W'($urandom_range(0, 257) * 254);
         default: return SEQ_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [TS_W-1:0] pick_stamp();
      case ($urandom_range(0, 4))
         0: return TS_W'($urandom_range(0, 70000));
         1: return TS_W'($urandom_range(0, 3) * 16387064 + $urandom_range(0, 2) * 64516);
         2: return TS_W'($urandom_range(0, 2000000000));
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   task automatic send_item(input mode_type mode, input logic [SEQ_W-1:0] seq,
                            input logic [TTL_W-1:0] ttl, input logic [TS_W-1:0] stamp,
                            input logic [BYTE_W-1:0] pbyte, input logic plast);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= mode;
      req_bus.seq_number   <= seq;
      req_bus.ttl_value    <= ttl;
      req_bus.timestamp_ms <= stamp;
      req_bus.payload_byte <= pbyte;
      req_bus.payload_last <= plast;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic send_header(input logic [SEQ_W-1:0] seq, input logic [TTL_W-1:0] ttl,
                              input logic [TS_W-1:0] stamp);
      send_item(MODE_HEADER, seq, ttl, stamp, BYTE_W'($urandom), 1'($urandom));
   endtask

   task automatic send_payload(input logic [BYTE_W-1:0] pbyte, input logic plast);
      send_item(MODE_PAYLOAD, SEQ_W'($urandom), TTL_W'($urandom),
                {16'($urandom), 32'($urandom)}, pbyte, plast);
   endtask

   task automatic send_datagram();
      int  length;
      bit  broken;
      length = $urandom_range(1, 10);
      broken = ($urandom_range(0, 9) == 0);
      send_header(pick_count(), pick_count(), pick_stamp());
      for (int i = 0; i < length; i++) begin
         if (broken && i == length / 2) begin
            send_header(pick_count(), pick_count(), pick_stamp());
         end
         send_payload(BYTE_W'($urandom), (i == length - 1) && !broken);
      end
   endtask

   initial begin
      int r;
      bit squeezed;
      bit drained;
      squeezed = 1'b0;
      drained  = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_HEADER;
      req_bus.seq_number   = '0;
      req_bus.ttl_value    = '0;
      req_bus.timestamp_ms = '0;
      req_bus.payload_byte = '0;
      req_bus.payload_last = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_header(16'd0, 16'd0, 48'd0);
      send_header(16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
      send_header(16'd64515, 16'd64516, 48'd999999999);
      send_header(16'd254, 16'd253, 48'd1000000000);
      send_header(16'd1, 16'd508, 48'd16387064);
      send_header(16'd255, 16'd1, 48'd254);
      send_header(16'd64514, 16'd64770, 48'd4162314255);
      send_payload(8'h00, 1'b0);
      send_payload(8'hFF, 1'b1);
      send_payload(8'hA5, 1'b0);
      send_payload(8'h5A, 1'b1);
      send_item(MODE_HEADER, 16'hAAAA, 16'h5555, 48'hAAAA_AAAA_AAAA, 8'hFF, 1'b1);
      send_item(MODE_PAYLOAD, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 8'h01, 1'b0);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (!squeezed && items_sent > 150) begin
            squeezed = 1'b1;
            @(negedge clock);
            req_bus.valid <= 1'b0;
            long_hold_req = 1'b1;
            wait (hold_active);
            tight = 1'b1;
            for (int i = 0; i < 30; i++) begin
               send_payload(BYTE_W'($urandom), 1'($urandom));
            end
            send_header(pick_count(), pick_count(), pick_stamp());
            tight = 1'b0;
         end
         if (!drained && items_sent > 300) begin
            drained = 1'b1;
            @(negedge clock);
            req_bus.valid <= 1'b0;
            wait (pending_count == 0);
         end
         r = $urandom_range(0, 99);
         tight = ($urandom_range(0, 4) == 0);
         if (r < 80) begin
            send_datagram();
         end else begin
            send_item(mode_type'($urandom_range(0, 1)), SEQ_W'($urandom), TTL_W'($urandom),
                      {16'($urandom), 32'($urandom)}, BYTE_W'($urandom), 1'($urandom));
         end
         tight = 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      wait (pending_count == 0);
      repeat (30) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      int r;
      int run;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         if (long_hold_req) begin
            hold_active = 1'b1;
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_req = 1'b0;
            hold_active   = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            @(negedge clock);
            if (r < 45) begin
               rsp_bus.ready <= 1'b1;
               run = $urandom_range(1, 12);
            end else if (r < 55) begin
               rsp_bus.ready <= 1'b1;
               run = $urandom_range(40, 120);
            end else if (r < 90) begin
               rsp_bus.ready <= 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               rsp_bus.ready <= 1'b0;
               run = $urandom_range(10, 40);
            end
            repeat (run - 1) @(negedge clock);
         end
      end
   end

endmodule
